// File: hdl/saw_pkg.sv
// Shared types, field widths and codes for the self-avoiding walk grower.
`default_nettype none
package saw_pkg;

   localparam int RANDOM_W    = 32;
   localparam int STATUS_W    = 2;
   localparam int COORD_OUT_W = 8;
   localparam int SITES_OUT_W = 7;
   localparam int DIST_OUT_W  = 13;
   localparam int WLEN_W      = 7;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 40;
   localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(64);

   localparam logic [STATUS_W-1:0] STATUS_EXTENDED  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_COMPLETED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TRAPPED   = 2'd2;

   localparam logic [1:0] DIR_POS_X = 2'd0;
   localparam logic [1:0] DIR_POS_Y = 2'd1;
   localparam logic [1:0] DIR_NEG_X = 2'd2;
   localparam logic [1:0] DIR_NEG_Y = 2'd3;

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_READ  = 7'b0000100,
      ST_WAIT  = 7'b0001000,
      ST_PICK  = 7'b0010000,
      ST_SQX   = 7'b0100000,
      ST_SQY   = 7'b1000000
   } state_type;

endpackage
`default_nettype wire

// File: hdl/self_avoiding_walk_grower_unit.sv
// Self-avoiding walk grower: lattice tag memory, neighbor scan sequencer, result register.
//
//  channel | direction | handshake           | payload
//  req     | in        | req_tvalid/tready   | tdata[31:0] random_word
//  rsp     | out       | rsp_tvalid/tready   | tdata: status, head_x, head_y, sites, distance
//  csr     | in        | csr_valid/csr_ready | csr_data[6:0] walk_length
//
// A request runs four neighbor reads, a capture step, the pick and the output load; a completed
// walk adds one square per axis through the one multiplier. The load waits for a free output
// register; req_tready returns in the cycle after the load unless a clearing pass follows.
// The lattice holds a generation tag per cell; restart just advances the tag. After reset
// and on each tag wrap, a clearing pass over the (2*MAX_LEN+1)^2 cells runs with req_tready low.
// Results wait in the output register; the next request runs meanwhile and holds at its end.
`default_nettype none
module self_avoiding_walk_grower_unit
   import saw_pkg::*;
#(
   parameter int MAX_LEN = 64,
   parameter int TAG_W   = 8
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  wire  [REQ_DATA_W-1:0] req_tdata,   // [31:0] random_word
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   // [1:0] step_status, [9:2] head_x, [17:10] head_y, [24:18] sites_used,
   // [37:25] squared_distance, [39:38] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  wire  [WLEN_W-1:0]     csr_data     // [6:0] walk_length
);

   localparam int GRID   = 2 * MAX_LEN + 1;
   localparam int CELLS  = GRID * GRID;
   localparam int CW     = $clog2(GRID);
   localparam int AW     = $clog2(CELLS);
   localparam int SW     = $clog2(MAX_LEN + 1);
   localparam int TW     = (SW > WLEN_W) ? SW : WLEN_W;
   localparam int HW     = (CW > COORD_OUT_W) ? CW : COORD_OUT_W;
   localparam int DW     = 2 * CW + 1;
   localparam int DXW    = (DW > DIST_OUT_W) ? DW : DIST_OUT_W;
   localparam int SXW    = (SW > SITES_OUT_W) ? SW : SITES_OUT_W;

   localparam logic [CW-1:0] CENTER    = CW'(MAX_LEN);
   localparam logic [CW-1:0] SEED_Y    = CW'(MAX_LEN + 1);
   localparam logic [CW-1:0] EDGE_HI   = CW'(GRID - 1);
   localparam logic [AW-1:0] ROW_STEP  = AW'(GRID);
   localparam logic [AW-1:0] SEED0_ADR = AW'(MAX_LEN * GRID + MAX_LEN);
   localparam logic [AW-1:0] SEED1_ADR = AW'(MAX_LEN * GRID + MAX_LEN + 1);
   localparam logic [AW-1:0] LAST_ADR  = AW'(CELLS - 1);
   localparam logic [TW-1:0] TGT_MIN   = TW'(2);
   localparam logic [TW-1:0] TGT_MAX   = TW'(MAX_LEN);
   localparam logic [TAG_W-1:0] TAG_FIRST = TAG_W'(1);
   localparam logic [TAG_W-1:0] TAG_LAST  = {TAG_W{1'b1}};

   logic [TAG_W-1:0] tag_mem [CELLS];

   state_type          state_ff, state_in;
   logic [1:0]         k_ff, k_in;
   logic [RANDOM_W-1:0] rnd_ff, rnd_in;
   logic [5:0]         dsum_ff, dsum_in;
   logic [1:0]         rd_k_ff;
   logic               rd_pend_ff, rd_blk_ff;
   logic [TAG_W-1:0]   rd_tag_ff;
   logic [3:0]         free_ff, free_in;
   logic [CW-1:0]      head_x_ff, head_x_in, head_y_ff, head_y_in;
   logic [AW-1:0]      head_adr_ff, head_adr_in;
   logic [SW-1:0]      sites_ff, sites_in;
   logic [TAG_W-1:0]   epoch_ff, epoch_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [WLEN_W-1:0]  wlen_ff, wlen_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [DW-1:0]      acc_ff, acc_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic [1:0]         dir_sel;
   logic [AW-1:0]      nb_adr;
   logic               nb_blk;
   logic [2:0]         nfree;
   logic [1:0]         pick_idx, pick_dir, pick_cnt;
   logic               pick_found;
   logic [3:0]         byte_sum, fold3;
   logic [1:0]         mod3;
   logic [TW-1:0]      wlen_ext, target;
   logic [SW-1:0]      sites_inc;
   logic [CW-1:0]      sq_coord, sq_mag;
   logic [2*CW-1:0]    sq_prod;
   logic               mem_we;
   logic [AW-1:0]      mem_wadr;
   logic [TAG_W-1:0]   mem_wdata;
   logic               out_free;
   logic [HW-1:0]      hx_ext, hy_ext;
   logic [SXW-1:0]     sites_ext;
   logic [DXW-1:0]     dist_ext;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Shared address adder: neighbor scan during reads, chosen step during the pick.
   assign dir_sel = (state_ff == ST_PICK) ? pick_dir : k_ff;
   always_comb begin
      case (dir_sel)
         DIR_POS_X: begin
            nb_adr = head_adr_ff + ROW_STEP;
            nb_blk = (head_x_ff == EDGE_HI);
         end
         DIR_POS_Y: begin
            nb_adr = head_adr_ff + AW'(1);
            nb_blk = (head_y_ff == EDGE_HI);
         end
         DIR_NEG_X: begin
            nb_adr = head_adr_ff - ROW_STEP;
            nb_blk = (head_x_ff == '0);
         end
         default: begin
            nb_adr = head_adr_ff - AW'(1);
            nb_blk = (head_y_ff == '0);
         end
      endcase
   end

   // Random word mod 3 folds one byte per read cycle: 4 == 1 mod 3.
   always_comb begin
      logic [7:0] b;
      b        = rnd_ff[8*k_ff +: 8];
      byte_sum = 4'(b[1:0]) + 4'(b[3:2]) + 4'(b[5:4]) + 4'(b[7:6]);
      fold3    = 4'(dsum_ff[1:0]) + 4'(dsum_ff[3:2]) + 4'(dsum_ff[5:4]);
      if (fold3 >= 4'd6) begin
         mod3 = 2'(fold3 - 4'd6);
      end else if (fold3 >= 4'd3) begin
         mod3 = 2'(fold3 - 4'd3);
      end else begin
         mod3 = fold3[1:0];
      end
   end

   // Choose among free neighbors in +x, +y, -x, -y order.
   always_comb begin
      nfree = 3'(free_ff[0]) + 3'(free_ff[1]) + 3'(free_ff[2]) + 3'(free_ff[3]);
      case (nfree)
         3'd2:    pick_idx = {1'b0, rnd_ff[0]};
         3'd3:    pick_idx = mod3;
         3'd4:    pick_idx = rnd_ff[1:0];
         default: pick_idx = 2'd0;
      endcase
      pick_dir   = DIR_POS_X;
      pick_cnt   = 2'd0;
      pick_found = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (free_ff[i] && !pick_found) begin
            if (pick_cnt == pick_idx) begin
               pick_dir   = 2'(i);
               pick_found = 1'b1;
            end else begin
               pick_cnt = pick_cnt + 2'd1;
            end
         end
      end
   end

   assign wlen_ext  = TW'(wlen_ff);
   assign target    = (wlen_ext < TGT_MIN) ? TGT_MIN :
                      (wlen_ext > TGT_MAX) ? TGT_MAX : wlen_ext;
   assign sites_inc = sites_ff + SW'(1);

   // One multiplier squares the x offset, then the y offset.
   assign sq_coord = (state_ff == ST_SQX) ? head_x_ff : head_y_ff;
   assign sq_mag   = (sq_coord >= CENTER) ? (sq_coord - CENTER) : (CENTER - sq_coord);
   assign sq_prod  = sq_mag * sq_mag;

   assign hx_ext    = HW'(head_x_ff);
   assign hy_ext    = HW'(head_y_ff);
   assign sites_ext = SXW'(sites_ff);
   assign dist_ext  = DXW'(acc_ff);
   assign out_free  = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      rnd_in        = rnd_ff;
      dsum_in       = dsum_ff;
      free_in       = free_ff;
      head_x_in     = head_x_ff;
      head_y_in     = head_y_ff;
      head_adr_in   = head_adr_ff;
      sites_in      = sites_ff;
      epoch_in      = epoch_ff;
      clr_in        = clr_ff;
      wlen_in       = wlen_ff;
      status_in     = status_ff;
      acc_in        = acc_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      mem_we        = 1'b0;
      mem_wadr      = nb_adr;
      mem_wdata     = epoch_ff;

      if (csr_valid) begin
         wlen_in = csr_data;
      end
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      if (rd_pend_ff) begin
         free_in[rd_k_ff] = !rd_blk_ff && (rd_tag_ff != epoch_ff);
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_wadr  = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == LAST_ADR) begin
               epoch_in = TAG_FIRST;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               rnd_in   = req_tdata;
               k_in     = DIR_POS_X;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            dsum_in = ((k_ff == DIR_POS_X) ? 6'd0 : dsum_ff) + 6'(byte_sum);
            k_in    = k_ff + 2'd1;
            if (k_ff == DIR_NEG_Y) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            state_in = ST_PICK;
         end
         ST_PICK: begin
            if (nfree == 3'd0) begin
               head_x_in   = CENTER;
               head_y_in   = SEED_Y;
               head_adr_in = SEED1_ADR;
               sites_in    = SW'(1);
               status_in   = STATUS_TRAPPED;
               acc_in      = '0;
               state_in    = ST_SQY;
            end else begin
               mem_we      = 1'b1;
               head_adr_in = nb_adr;
               sites_in    = sites_inc;
               case (pick_dir)
                  DIR_POS_X: head_x_in = head_x_ff + CW'(1);
                  DIR_POS_Y: head_y_in = head_y_ff + CW'(1);
                  DIR_NEG_X: head_x_in = head_x_ff - CW'(1);
                  default:   head_y_in = head_y_ff - CW'(1);
               endcase
               acc_in = '0;
               if (TW'(sites_inc) >= target) begin
                  status_in = STATUS_COMPLETED;
                  state_in  = ST_SQX;
               end else begin
                  status_in = STATUS_EXTENDED;
                  state_in  = ST_SQY;
               end
            end
         end
         ST_SQX: begin
            acc_in   = DW'(sq_prod);
            // mark the y square as still to come
            k_in     = DIR_NEG_Y;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            // Only a completed walk accumulates the y square; hold until the output frees.
            if (status_ff == STATUS_COMPLETED && state_ff == ST_SQY && k_ff == DIR_NEG_Y) begin
               acc_in = acc_ff + DW'(sq_prod);
               k_in   = DIR_POS_X;
            end else if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {2'b00, dist_ext[DIST_OUT_W-1:0], sites_ext[SITES_OUT_W-1:0],
                                hy_ext[COORD_OUT_W-1:0], hx_ext[COORD_OUT_W-1:0], status_ff};
               state_in      = ST_IDLE;
               if (status_ff != STATUS_EXTENDED) begin
                  head_x_in   = CENTER;
                  head_y_in   = SEED_Y;
                  head_adr_in = SEED1_ADR;
                  sites_in    = SW'(1);
                  if (epoch_ff == TAG_LAST) begin
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end else begin
                     epoch_in = epoch_ff + TAG_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Tag memory: one write port, one registered read port; seed cells always count as taken.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tag_mem[mem_wadr] <= mem_wdata;
      end
      rd_tag_ff <= tag_mem[nb_adr];
      rd_k_ff   <= k_ff;
      rd_blk_ff <= nb_blk || (nb_adr == SEED0_ADR) || (nb_adr == SEED1_ADR);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         k_ff          <= DIR_NEG_Y;
         rd_pend_ff    <= 1'b0;
         head_x_ff     <= CENTER;
         head_y_ff     <= SEED_Y;
         head_adr_ff   <= SEED1_ADR;
         sites_ff      <= SW'(1);
         epoch_ff      <= TAG_FIRST;
         clr_ff        <= '0;
         wlen_ff       <= WLEN_RESET;
         status_ff     <= STATUS_EXTENDED;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         k_ff          <= k_in;
         rd_pend_ff    <= (state_ff == ST_READ);
         head_x_ff     <= head_x_in;
         head_y_ff     <= head_y_in;
         head_adr_ff   <= head_adr_in;
         sites_ff      <= sites_in;
         epoch_ff      <= epoch_in;
         clr_ff        <= clr_in;
         wlen_ff       <= wlen_in;
         status_ff     <= status_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rnd_ff       <= rnd_in;
      dsum_ff      <= dsum_in;
      free_ff      <= free_in;
      acc_ff       <= acc_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

endmodule
`default_nettype wire
